// ===== src/udprx_pkg.sv =====
// udprx_pkg: shared types and constants for the udp receive checksum and port filter
// no dependencies; imported by udp_receive_checksum_port_filter

package udprx_pkg;

   localparam int PORT_SLOTS    = 6;
   localparam int MAX_SLOT_REGS = 6;
   localparam int SLOT_W        = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int MIN_SEG_BYTES = 8;

   localparam logic [15:0] UDP_PROTO = 16'd17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LOCAL_IP    = 3'd0,
      REG_OPEN_MASK   = 3'd1,
      REG_PORT_SLOT_0 = 3'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      VERDICT_DELIVER   = 2'd0,
      VERDICT_BAD_CSUM  = 2'd1,
      VERDICT_NO_PORT   = 2'd2,
      VERDICT_TOO_SHORT = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0]  seg_byte;
      logic        seg_last;
      logic [31:0] peer_ip;
   } req_item_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [15:0]       dest_port;
      logic [15:0]       source_port;
      logic [SLOT_W-1:0] slot_hit;
      logic [15:0]       payload_bytes;
   } rsp_item_type;

endpackage

// ===== src/udp_receive_checksum_port_filter.sv =====
// udp_receive_checksum_port_filter: byte-wide udp receive checksum and port filter
// depends on udprx_pkg for item types, register indexes and verdict codes

// Takes one segment byte per clock for any segment length; only a last byte can stall.
// Each byte passes an input register, then a segment stage that folds it into the
// 16-bit ones'-complement sum with one end-around-carry add; the last byte moves the
// segment totals into a finish register, where the pseudo-header is added and the
// port slots are compared, and the verdict is then registered in the result register.
// Bytes that are not last give no result. The input side keeps taking bytes while a
// verdict waits on rsp_ready; a last byte waits only while the finish and result
// registers are both full. Configuration writes are always taken (csr_ready
// is tied high) and must be made only while no segment is in flight.

module udp_receive_checksum_port_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  udprx_pkg::req_item_type             req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output udprx_pkg::rsp_item_type             rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [udprx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [udprx_pkg::CSR_DATA_W-1:0]    csr_data
);

   import udprx_pkg::*;

   // configuration
   logic [31:0]              local_ip_ff;
   logic [MAX_SLOT_REGS-1:0] open_mask_ff;
   logic [15:0]              port_slot_ff [MAX_SLOT_REGS];

   // input register
   logic         a_valid_ff;
   req_item_type a_item_ff;

   // segment state
   logic [15:0] byte_count_ff,  byte_count_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  high_hold_ff,   high_hold_in;
   logic [15:0] rx_csum_ff,     rx_csum_in;
   logic [15:0] dst_port_ff,    dst_port_in;
   logic [15:0] src_port_ff,    src_port_in;
   logic [31:0] peer_ip_ff,     peer_ip_in;
   logic        seg_long_ff,    seg_long_in;

   // finish register
   logic        b_valid_ff;
   logic [15:0] b_sum_ff, b_sum_in;
   logic [31:0] b_peer_ff, b_peer_in;
   logic [15:0] b_len_ff, b_len_in;
   logic        b_long_ff, b_long_in;
   logic [15:0] b_csum_ff, b_csum_in;
   logic [15:0] b_dport_ff, b_dport_in;
   logic [15:0] b_sport_ff, b_sport_in;

   // result register
   logic         c_valid_ff;
   rsp_item_type c_item_ff, c_item_in;

   logic a_go, a_last, b_ready, b_load, c_ready, b_go;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // handshakes
   assign c_ready   = !c_valid_ff || rsp_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign b_go      = b_valid_ff && c_ready;
   assign a_last    = a_item_ff.seg_last;
   assign a_go      = a_valid_ff && (!a_last || b_ready);
   assign b_load    = a_go && a_last;
   assign req_ready = !a_valid_ff || a_go;
   assign csr_ready = 1'b1;
   assign rsp_valid = c_valid_ff;
   assign rsp_item  = c_item_ff;

   // segment stage
   always_comb begin
      logic [15:0] pos;
      logic        even;
      logic        cap;
      logic [7:0]  word;
      logic [15:0] sum_fin;
      logic [15:0] count_inc;
      logic [15:0] src_sel, dst_sel, csum_sel;
      logic [31:0] peer_sel;
      logic        long_sel;

      pos       = byte_count_ff;
      even      = !pos[0];
      cap       = !seg_long_ff;
      word      = (cap && (pos == 16'd6 || pos == 16'd7)) ? 8'd0 : a_item_ff.seg_byte;
      sum_fin   = oc_add(running_sum_ff,
                         even ? {word, 8'h00} : {high_hold_ff, word});
      count_inc = pos + 16'd1;
      long_sel  = seg_long_ff || (count_inc == 16'd0);
      peer_sel  = (cap && pos == 16'd0) ? a_item_ff.peer_ip : peer_ip_ff;
      src_sel   = src_port_ff;
      dst_sel   = dst_port_ff;
      csum_sel  = rx_csum_ff;
      if (cap) begin
         case (pos)
            16'd0:   src_sel  = {a_item_ff.seg_byte, src_port_ff[7:0]};
            16'd1:   src_sel  = {src_port_ff[15:8], a_item_ff.seg_byte};
            16'd2:   dst_sel  = {a_item_ff.seg_byte, dst_port_ff[7:0]};
            16'd3:   dst_sel  = {dst_port_ff[15:8], a_item_ff.seg_byte};
            16'd6:   csum_sel = {a_item_ff.seg_byte, rx_csum_ff[7:0]};
            16'd7:   csum_sel = {rx_csum_ff[15:8], a_item_ff.seg_byte};
            default: ;
         endcase
      end

      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      high_hold_in   = high_hold_ff;
      rx_csum_in     = rx_csum_ff;
      dst_port_in    = dst_port_ff;
      src_port_in    = src_port_ff;
      peer_ip_in     = peer_ip_ff;
      seg_long_in    = seg_long_ff;

      if (a_go) begin
         peer_ip_in = peer_sel;
         if (a_last) begin
            byte_count_in  = 16'd0;
            running_sum_in = 16'd0;
            high_hold_in   = 8'd0;
            rx_csum_in     = 16'd0;
            dst_port_in    = 16'd0;
            src_port_in    = 16'd0;
            seg_long_in    = 1'b0;
         end else begin
            byte_count_in  = count_inc;
            running_sum_in = even ? running_sum_ff : sum_fin;
            high_hold_in   = even ? word : 8'd0;
            rx_csum_in     = csum_sel;
            dst_port_in    = dst_sel;
            src_port_in    = src_sel;
            seg_long_in    = long_sel;
         end
      end

      b_sum_in   = sum_fin;
      b_peer_in  = peer_sel;
      b_len_in   = count_inc;
      b_long_in  = long_sel;
      b_csum_in  = csum_sel;
      b_dport_in = dst_sel;
      b_sport_in = src_sel;
   end

   // finish stage: pseudo-header and port lookup
   always_comb begin
      logic [18:0]       total;
      logic [16:0]       fold1;
      logic [15:0]       final_sum;
      logic              hit;
      logic [SLOT_W-1:0] slot;

      total = 19'(b_sum_ff) + 19'(b_peer_ff[31:16]) + 19'(b_peer_ff[15:0])
            + 19'(local_ip_ff[31:16]) + 19'(local_ip_ff[15:0])
            + 19'(UDP_PROTO) + 19'(b_len_ff);
      fold1     = {1'b0, total[15:0]} + 17'(total[18:16]);
      final_sum = fold1[15:0] + {15'd0, fold1[16]};

      hit  = 1'b0;
      slot = '0;
      for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
         if (open_mask_ff[i] && port_slot_ff[i] == b_dport_ff) begin
            hit  = 1'b1;
            slot = SLOT_W'(i);
         end
      end

      c_item_in.verdict       = VERDICT_DELIVER;
      c_item_in.dest_port     = b_dport_ff;
      c_item_in.source_port   = b_sport_ff;
      c_item_in.slot_hit      = '0;
      c_item_in.payload_bytes = 16'd0;
      if (!b_long_ff && b_len_ff < 16'(MIN_SEG_BYTES)) begin
         c_item_in.verdict     = VERDICT_TOO_SHORT;
         c_item_in.dest_port   = 16'd0;
         c_item_in.source_port = 16'd0;
      end else if (b_csum_ff != ~final_sum) begin
         c_item_in.verdict = VERDICT_BAD_CSUM;
      end else if (!hit) begin
         c_item_in.verdict = VERDICT_NO_PORT;
      end else begin
         c_item_in.slot_hit      = slot;
         c_item_in.payload_bytes = b_len_ff - 16'(MIN_SEG_BYTES);
      end
   end

   // control, segment state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         byte_count_ff  <= 16'd0;
         running_sum_ff <= 16'd0;
         high_hold_ff   <= 8'd0;
         rx_csum_ff     <= 16'd0;
         dst_port_ff    <= 16'd0;
         src_port_ff    <= 16'd0;
         peer_ip_ff     <= 32'd0;
         seg_long_ff    <= 1'b0;
         local_ip_ff    <= 32'd0;
         open_mask_ff   <= '0;
         for (int i = 0; i < MAX_SLOT_REGS; i++) begin
            port_slot_ff[i] <= 16'd0;
         end
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_ready) begin
            b_valid_ff <= b_load;
         end
         if (c_ready) begin
            c_valid_ff <= b_go;
         end
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         high_hold_ff   <= high_hold_in;
         rx_csum_ff     <= rx_csum_in;
         dst_port_ff    <= dst_port_in;
         src_port_ff    <= src_port_in;
         peer_ip_ff     <= peer_ip_in;
         seg_long_ff    <= seg_long_in;
         if (csr_valid) begin
            case (csr_index)
               REG_LOCAL_IP:  local_ip_ff  <= csr_data;
               REG_OPEN_MASK: open_mask_ff <= csr_data[MAX_SLOT_REGS-1:0];
               default: begin
                  port_slot_ff[SLOT_W'(csr_index - REG_PORT_SLOT_0)] <= csr_data[15:0];
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_item_ff <= req_item;
      end
      if (b_load) begin
         b_sum_ff   <= b_sum_in;
         b_peer_ff  <= b_peer_in;
         b_len_ff   <= b_len_in;
         b_long_ff  <= b_long_in;
         b_csum_ff  <= b_csum_in;
         b_dport_ff <= b_dport_in;
         b_sport_ff <= b_sport_in;
      end
      if (b_go) begin
         c_item_ff <= c_item_in;
      end
   end

   // checks
   a_new_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      !c_valid_ff ##1 c_valid_ff |-> $past(b_valid_ff))
      else $error("result appeared without a finished segment");

   a_segment_cleared: assert property (@(posedge clock) disable iff (reset)
      b_load |=> (byte_count_ff == 16'd0 && !seg_long_ff && running_sum_ff == 16'd0))
      else $error("segment state not cleared after last item");

   a_short_no_ports: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && c_item_ff.verdict == VERDICT_TOO_SHORT |->
         (c_item_ff.dest_port == 16'd0 && c_item_ff.source_port == 16'd0))
      else $error("too short verdict carries ports");

   a_drop_no_payload: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && c_item_ff.verdict != VERDICT_DELIVER |->
         (c_item_ff.slot_hit == '0 && c_item_ff.payload_bytes == 16'd0))
      else $error("dropped item carries slot or payload length");

endmodule

// ===== verif/udp_receive_checksum_port_filter_tb.sv =====
// udp_receive_checksum_port_filter_tb: self-checking bench for the udp receive checksum and port filter
// drives byte segments, register writes and result stalls, and predicts each verdict
// depends on udprx_pkg and udp_receive_checksum_port_filter

module udp_receive_checksum_port_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import udprx_pkg::*;

   typedef enum {CSUM_GOOD, CSUM_BAD, CSUM_ZERO} csum_mode_type;
   typedef enum {CFG_DIRECTED, CFG_LOW, CFG_HIGH, CFG_RANDOM} cfg_kind_type;

   class udp_verdict_board;
      logic [31:0] local_ip;
      logic [5:0]  open_mask;
      logic [15:0] slot_port [MAX_SLOT_REGS];
      logic [15:0] byte_count;
      logic [15:0] run_sum;
      logic [7:0]  hi_byte;
      logic [15:0] rx_csum;
      logic [15:0] dport;
      logic [15:0] sport;
      logic [31:0] peer_hold;
      bit          seg_long;
      rsp_item_type expected_verdicts [$];
      int          mismatch_count;

      function new();
         local_ip = '0;
         open_mask = '0;
         foreach (slot_port[i]) slot_port[i] = '0;
         peer_hold = '0;
         mismatch_count = 0;
         clear_segment();
      endfunction

      function void clear_segment();
         byte_count = '0;
         run_sum = '0;
         hi_byte = '0;
         rx_csum = '0;
         dport = '0;
         sport = '0;
         seg_long = 1'b0;
      endfunction

      function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[15:0] + {15'd0, s[16]};
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_LOCAL_IP:  local_ip = data;
            REG_OPEN_MASK: open_mask = data[5:0];
            default:       slot_port[idx - REG_PORT_SLOT_0] = data[15:0];
         endcase
      endfunction

      function void take_byte(req_item_type item);
         logic [15:0] pos;
         logic [15:0] len;
         logic [7:0]  b;
         logic [7:0]  w;
         rsp_item_type r;
         b = item.seg_byte;
         pos = byte_count;
         if (pos == 0 && !seg_long) peer_hold = item.peer_ip;
         if (!seg_long) begin
            case (pos)
               0: sport[15:8] = b;
               1: sport[7:0] = b;
               2: dport[15:8] = b;
               3: dport[7:0] = b;
               6: rx_csum[15:8] = b;
               7: rx_csum[7:0] = b;
               default: ;
            endcase
         end
         // checksum field counts as zero
         w = (!seg_long && (pos == 6 || pos == 7)) ? 8'h00 : b;
         if (!pos[0]) begin
            hi_byte = w;
         end else begin
            run_sum = ones_add(run_sum, {hi_byte, w});
            hi_byte = '0;
         end
         byte_count = pos + 16'd1;
         if (byte_count == 0) seg_long = 1'b1;
         if (!item.seg_last) return;

         len = byte_count;
         if (!pos[0]) run_sum = ones_add(run_sum, {hi_byte, 8'h00});
         run_sum = ones_add(run_sum, peer_hold[31:16]);
         run_sum = ones_add(run_sum, peer_hold[15:0]);
         run_sum = ones_add(run_sum, local_ip[31:16]);
         run_sum = ones_add(run_sum, local_ip[15:0]);
         run_sum = ones_add(run_sum, UDP_PROTO);
         run_sum = ones_add(run_sum, len);

         r = '0;
         r.dest_port = dport;
         r.source_port = sport;
         if (!seg_long && len < MIN_SEG_BYTES) begin
            r.verdict = VERDICT_TOO_SHORT;
            r.dest_port = '0;
            r.source_port = '0;
         end else if (rx_csum != ~run_sum) begin
            r.verdict = VERDICT_BAD_CSUM;
         end else begin
            r.verdict = VERDICT_NO_PORT;
            for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
               if (open_mask[i] && slot_port[i] == dport) begin
                  r.verdict = VERDICT_DELIVER;
                  r.slot_hit = SLOT_W'(i);
                  r.payload_bytes = len - 16'd8;
               end
            end
         end
         expected_verdicts.push_back(r);
         clear_segment();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
         mismatch_count++;
      endtask

      task check_verdict(rsp_item_type got);
         rsp_item_type want;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected verdict", got.verdict, 0);
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.verdict !== want.verdict)
            report_mismatch("verdict", got.verdict, want.verdict);
         if (got.dest_port !== want.dest_port)
            report_mismatch("dest_port", got.dest_port, want.dest_port);
         if (got.source_port !== want.source_port)
            report_mismatch("source_port", got.source_port, want.source_port);
         if (got.slot_hit !== want.slot_hit)
            report_mismatch("slot_hit", got.slot_hit, want.slot_hit);
         if (got.payload_bytes !== want.payload_bytes)
            report_mismatch("payload_bytes", got.payload_bytes, want.payload_bytes);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   udp_verdict_board board = new();
   logic [7:0] seg_data [$];
   int req_gap_pct;
   int rsp_stall_pct;

   udp_receive_checksum_port_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) board.take_byte(req_item);
         if (rsp_valid && rsp_ready) board.check_verdict(rsp_item);
      end
   end

   function automatic logic [15:0] segment_checksum(logic [31:0] peer);
      logic [15:0] acc;
      logic [7:0]  hi;
      logic [7:0]  b;
      int          n;
      acc = '0;
      hi = '0;
      n = seg_data.size();
      for (int k = 0; k < n; k++) begin
         b = (k == 6 || k == 7) ? 8'h00 : seg_data[k];
         if (k % 2 == 0) hi = b;
         else acc = board.ones_add(acc, {hi, b});
      end
      if (n % 2) acc = board.ones_add(acc, {hi, 8'h00});
      acc = board.ones_add(acc, peer[31:16]);
      acc = board.ones_add(acc, peer[15:0]);
      acc = board.ones_add(acc, board.local_ip[31:16]);
      acc = board.ones_add(acc, board.local_ip[15:0]);
      acc = board.ones_add(acc, UDP_PROTO);
      acc = board.ones_add(acc, 16'(n));
      return ~acc;
   endfunction

   task automatic make_segment(int n, logic [15:0] dst, csum_mode_type mode, logic [31:0] peer);
      logic [15:0] src;
      logic [15:0] csum;
      seg_data.delete();
      for (int k = 0; k < n; k++) seg_data.push_back(8'($urandom_range(255)));
      if (n >= MIN_SEG_BYTES) begin
         src = 16'($urandom);
         seg_data[0] = src[15:8];
         seg_data[1] = src[7:0];
         seg_data[2] = dst[15:8];
         seg_data[3] = dst[7:0];
         seg_data[4] = 8'(n >> 8);
         seg_data[5] = 8'(n);
         // zero checksum: length field absorbs the sum so zero is the right value
         if (mode == CSUM_ZERO) begin
            seg_data[4] = 8'h00;
            seg_data[5] = 8'h00;
         end
         csum = segment_checksum(peer);
         case (mode)
            CSUM_GOOD: begin
               seg_data[6] = csum[15:8];
               seg_data[7] = csum[7:0];
            end
            CSUM_BAD: begin
               csum = csum ^ 16'($urandom_range(1, 65535));
               seg_data[6] = csum[15:8];
               seg_data[7] = csum[7:0];
            end
            default: begin
               seg_data[4] = csum[15:8];
               seg_data[5] = csum[7:0];
               seg_data[6] = 8'h00;
               seg_data[7] = 8'h00;
            end
         endcase
      end
   endtask

   task automatic send_byte(req_item_type item);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_segment(logic [31:0] peer);
      req_item_type item;
      for (int k = 0; k < seg_data.size(); k++) begin
         item.seg_byte = seg_data[k];
         item.seg_last = (k == seg_data.size() - 1);
         // peer address only counts on the first byte
         item.peer_ip = (k == 0) ? peer : 32'($urandom);
         send_byte(item);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_config(cfg_kind_type kind);
      logic [31:0] lip;
      logic [5:0]  mask;
      logic [15:0] port [MAX_SLOT_REGS];
      lip = $urandom;
      mask = 6'($urandom);
      foreach (port[i]) port[i] = 16'($urandom);
      case (kind)
         CFG_DIRECTED: begin
            lip = 32'hC0A8_0102;
            mask = 6'b010110;
            port[0] = 16'd53;
            port[1] = 16'd80;
            port[2] = 16'hFFFF;
            port[3] = 16'h0000;
            port[4] = 16'd80;
            port[5] = 16'h1234;
         end
         CFG_LOW: begin
            lip = '0;
            mask = 6'h3F;
            port[0] = 16'h0000;
            port[5] = 16'hFFFF;
            port[3] = port[1];
         end
         CFG_HIGH: begin
            lip = '1;
            mask = '0;
         end
         default: port[4] = port[2];
      endcase
      write_csr(REG_LOCAL_IP, lip);
      write_csr(REG_OPEN_MASK, {26'($urandom), mask});
      for (int i = 0; i < MAX_SLOT_REGS; i++)
         write_csr(CSR_INDEX_W'(REG_PORT_SLOT_0 + i), {16'($urandom), port[i]});
      csr_valid = 1'b0;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (board.expected_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_block(int byte_budget);
      int            sent;
      int            n;
      int            pick;
      logic [15:0]   dst;
      logic [31:0]   peer;
      csum_mode_type mode;
      sent = 0;
      while (sent < byte_budget) begin
         n = ($urandom_range(99) < 15) ? $urandom_range(1, 7) : $urandom_range(8, 24);
         dst = ($urandom_range(99) < 70) ? board.slot_port[$urandom_range(MAX_SLOT_REGS - 1)]
                                         : 16'($urandom);
         pick = $urandom_range(99);
         mode = (pick < 75) ? CSUM_GOOD : ((pick < 88) ? CSUM_BAD : CSUM_ZERO);
         peer = $urandom;
         make_segment(n, dst, mode, peer);
         send_segment(peer);
         sent += n;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_gap_pct = 36;
      rsp_stall_pct = 60;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      program_config(CFG_DIRECTED);
      make_segment(1, 16'd80, CSUM_GOOD, 32'hFFFF_FFFF);
      send_segment(32'hFFFF_FFFF);
      make_segment(8, 16'd80, CSUM_ZERO, 32'h0000_0000);
      send_segment(32'h0000_0000);
      make_segment(9, 16'hFFFF, CSUM_BAD, 32'hFFFF_FFFF);
      send_segment(32'hFFFF_FFFF);
      make_segment(8, 16'd53, CSUM_GOOD, 32'h0A00_0001);
      send_segment(32'h0A00_0001);

      for (int blk = 0; blk < 6; blk++) begin
         settle();
         req_gap_pct = (blk < 2) ? 36 : ((blk < 4) ? 60 : 0);
         rsp_stall_pct = (blk < 2) ? 60 : ((blk < 4) ? 36 : 0);
         program_config((blk == 0) ? CFG_LOW : ((blk == 1) ? CFG_HIGH : CFG_RANDOM));
         run_block(87);
      end

      settle();
      repeat (10) @(negedge clock);
      if (board.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
